[sv/assert_macros.svh]
// Assertion macros shared by the sanitizer RTL.
// Needs signals named clk and arst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every rising edge outside reset
`define ASSERT_AT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// cond must never be true at a rising edge outside reset
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

[sv/utf8s_pkg.sv]
// Package for the UTF-8 sanitizer: beat types, queue command type,
// replacement bytes and sequence decode functions. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package utf8s_pkg;

	localparam int QUEUE_DEPTH_DEF = 2;

	localparam logic [7:0] REPL_B0 = 8'hEF;
	localparam logic [7:0] REPL_B1 = 8'hBF;
	localparam logic [7:0] REPL_B2 = 8'hBD;

	typedef logic [3:0][7:0] win_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       byte_present;
		logic       string_end;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_replacement;
		logic       run_last;
		logic       string_last;
	} out_beat_t;

	// one decided sequence (or one replacement) handed from front to back
	typedef struct packed {
		win_t       bytes;
		logic [2:0] len;
		logic       repl;
		logic       run_last;
		logic       string_last;
	} cmd_t;

	// sequence length from the lead byte, 0 for a bad lead
	function automatic logic [2:0] seq_len(input logic [7:0] b);
		logic [2:0] r;
		if (b[7] == 1'b0) r = 3'd1;
		else if (b[7:5] == 3'b110) r = 3'd2;
		else if (b[7:4] == 4'b1110) r = 3'd3;
		else if (b[7:3] == 5'b11110) r = 3'd4;
		else r = 3'd0;
		return r;
	endfunction

	// checks a complete sequence of len bytes at w[0]
	function automatic logic seq_ok(input win_t w, input logic [2:0] len);
		logic [20:0] cp;
		logic        c1;
		logic        c2;
		logic        c3;
		logic        r;
		cp = '0;
		c1 = (w[1][7:6] == 2'b10);
		c2 = (w[2][7:6] == 2'b10);
		c3 = (w[3][7:6] == 2'b10);
		case (len)
			3'd1: begin
				r = 1'b1;
			end
			3'd2: begin
				cp = {10'd0, w[0][4:0], w[1][5:0]};
				r = c1 && (cp >= 21'h80);
			end
			3'd3: begin
				cp = {5'd0, w[0][3:0], w[1][5:0], w[2][5:0]};
				r = c1 && c2 && (cp >= 21'h800) &&
					!((cp >= 21'hD800) && (cp <= 21'hDFFF));
			end
			3'd4: begin
				cp = {w[0][2:0], w[1][5:0], w[2][5:0], w[3][5:0]};
				r = c1 && c2 && c3 && (cp >= 21'h10000) && (cp <= 21'h10FFFF);
			end
			default: begin
				r = 1'b0;
			end
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

[sv/utf8s_front.sv]
// Front end: input beats fill a 4-byte window; decides one sequence per cycle
// and pushes it to the queue if not full. Uses utf8s_pkg, assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
module utf8s_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire utf8s_pkg::in_beat_t item,
	output logic                    cmd_valid,
	output utf8s_pkg::cmd_t         cmd,
	input  wire logic               cmd_ready
);
	import utf8s_pkg::*;
	`include "assert_macros.svh"

	win_t       win_q;      // held bytes; entries at and above cnt_q are junk
	logic [2:0] cnt_q;
	logic       at_end_q;

	logic [2:0] len0, len1, adv, cnt_nx, sel;
	logic       ok, need, need_nx, step, accept;
	win_t       win_sh;

	always_comb begin
		len0 = seq_len(win_q[0]);
		need = (cnt_q != 3'd0) && !((len0 != 3'd0) && (cnt_q < len0) && !at_end_q);
		ok   = (len0 != 3'd0) && (cnt_q >= len0) && seq_ok(win_q, len0);
		adv  = ok ? len0 : 3'd1;
		cnt_nx = cnt_q - adv;
		for (int i = 0; i < 4; i++) begin
			sel = 3'(i) + adv;
			win_sh[i] = (sel <= 3'd3) ? win_q[sel[1:0]] : 8'h00;
		end
		len1 = seq_len(win_sh[0]);
		need_nx = (cnt_nx != 3'd0) &&
			!((len1 != 3'd0) && (cnt_nx < len1) && !at_end_q);
	end

	assign full      = need;
	assign accept    = push && !need;
	assign step      = need && cmd_ready;
	assign cmd_valid = need;

	always_comb begin
		cmd.bytes       = ok ? win_q : {8'h00, REPL_B2, REPL_B1, REPL_B0};
		cmd.len         = ok ? len0 : 3'd3;
		cmd.repl        = !ok;
		cmd.run_last    = !need_nx;
		cmd.string_last = !need_nx && at_end_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= 3'd0;
			at_end_q <= 1'b0;
		end else if (step) begin
			cnt_q <= cnt_nx;
		end else if (accept) begin
			cnt_q    <= cnt_q + {2'd0, item.byte_present};
			at_end_q <= item.string_end;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			win_q <= win_sh;
		end else if (accept && item.byte_present) begin
			win_q[cnt_q[1:0]] <= item.in_byte;
		end
	end

	// with four bytes held a decision is always due, so a load never overruns
	`ASSERT_AT(a_idle_fits, !need |-> (cnt_q <= 3'd3), "front idle with full window")
	// a command closing a string must leave nothing pending
	`ASSERT_AT(a_end_flush, (step && cmd.string_last) |=> (cnt_q == 3'd0), "pending left at end")

endmodule
`default_nettype wire

[sv/utf8s_fifo.sv]
// Short command queue between front and back end.
// Uses utf8s_pkg, assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
module utf8s_fifo #(
	parameter int DEPTH = utf8s_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            wr,
	input  wire utf8s_pkg::cmd_t wdata,
	output logic                 full,
	input  wire logic            rd,
	output utf8s_pkg::cmd_t      rdata,
	output logic                 empty
);
	import utf8s_pkg::*;
	`include "assert_macros.svh"

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          slot_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;

	function automatic logic [AW-1:0] nxt(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = slot_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= nxt(wp_q);
			if (rd) rp_q <= nxt(rp_q);
			if (wr && !rd) cnt_q <= cnt_q + CW'(1);
			else if (rd && !wr) cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) slot_q[wp_q] <= wdata;
	end

	`ASSERT_NEVER(a_no_overflow, wr && full, "write to full queue")
	`ASSERT_NEVER(a_no_underflow, rd && empty, "read from empty queue")

endmodule
`default_nettype wire

[sv/utf8s_back.sv]
// Back end: expands queued commands into result beats, one byte per pop.
// Uses utf8s_pkg, assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
module utf8s_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            q_empty,
	input  wire utf8s_pkg::cmd_t q_data,
	output logic                 q_rd,
	output logic                 empty,
	input  wire logic            pop,
	output utf8s_pkg::out_beat_t result
);
	import utf8s_pkg::*;
	`include "assert_macros.svh"

	cmd_t       cur_q;
	logic       cur_vld_q;
	logic [1:0] idx_q;
	logic       last_byte, take;

	assign last_byte = ({1'b0, idx_q} + 3'd1) == cur_q.len;
	assign empty     = !cur_vld_q;
	assign take      = pop && cur_vld_q;
	assign q_rd      = (!cur_vld_q || (take && last_byte)) && !q_empty;

	always_comb begin
		result.out_byte       = cur_q.bytes[idx_q];
		result.is_replacement = cur_q.repl;
		result.run_last       = cur_q.run_last && last_byte;
		result.string_last    = cur_q.string_last && last_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_vld_q <= 1'b0;
			idx_q     <= 2'd0;
		end else if (q_rd) begin
			cur_vld_q <= 1'b1;
			idx_q     <= 2'd0;
		end else if (take) begin
			if (last_byte) begin
				cur_vld_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd) cur_q <= q_data;
	end

	`ASSERT_AT(a_idx_in_seq, cur_vld_q |-> ({1'b0, idx_q} < cur_q.len), "byte index past sequence")
	`ASSERT_AT(a_drain, (take && last_byte && q_empty) |=> empty, "stale beat after drain")

endmodule
`default_nettype wire

[sv/utf8_sanitizer.sv]
// UTF-8 sanitizer top: accepted byte goes into a 4-byte window; the front end
// decides one sequence or replacement per cycle unless the queue is full; the back end
// sends one byte per pop. An accepted byte is registered in the window; the decision
// is written into the queue, then loaded into the back-end register that drives result.
// The front takes no beat while a decision is due; output is one byte per cycle at most.
// Reset (arst_n low, async): pending count, queue and output valid clear.
`timescale 1ns / 1ps
`default_nettype none
module utf8_sanitizer #(
	parameter int QUEUE_DEPTH = utf8s_pkg::QUEUE_DEPTH_DEF  // 2 or more
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// input side: queue-style, beat taken on push && !full
	input  wire logic                 push,
	output logic                      full,
	input  wire utf8s_pkg::in_beat_t  item,
	// result side: oldest byte on result while !empty, taken on pop && !empty
	output logic                      empty,
	input  wire logic                 pop,
	output utf8s_pkg::out_beat_t      result
);
	import utf8s_pkg::*;

	// front -> queue
	logic cmd_valid, q_full, q_wr;
	cmd_t cmd;
	// queue -> back
	logic q_rd, q_empty;
	cmd_t q_data;

	assign q_wr = cmd_valid && !q_full;

	// The front holds the pending prefix of an incomplete sequence in its
	// window; full stays high while a decision is still due on that window.
	utf8s_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_ready (!q_full)
	);

	// Decouples decision rate from the byte-wide output.
	utf8s_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.wdata  (cmd),
		.full   (q_full),
		.rd     (q_rd),
		.rdata  (q_data),
		.empty  (q_empty)
	);

	// Serializes each command (1-4 passed bytes or EF BF BD) into beats;
	// run_last and string_last ride only on a command's final byte.
	utf8s_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_data  (q_data),
		.q_rd    (q_rd),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule
`default_nettype wire

[sim/testbench.sv]
// Self-checking testbench for utf8_sanitizer: byte beats in, repaired UTF-8 beats out.
// Depends on utf8s_pkg (beat types, replacement bytes) and the utf8_sanitizer RTL.
`timescale 1ns / 1ps
module testbench;
	import utf8s_pkg::*;

	// watchdog: far above the slowest legal run (~300 beats, up to 12 result
	// beats each, pops stalled more than half the time)
	localparam int CYCLE_LIMIT = 200000;
	// settle time at the end: result latency plus queue slack
	localparam int SETTLE_CYCLES = 20;
	localparam int BEATS_PER_PHASE = 52;

	// Scoreboard: carries its own copy of the held prefix and predicts the
	// repaired output for every accepted input beat.
	class repair_board;
		out_beat_t  repaired_q[$];
		logic [7:0] held[3];
		int         held_n = 0;
		int         mismatches = 0;
		logic [7:0] win[4];

		// sequence length from the lead byte, 0 for a byte that cannot lead
		function int lead_len(logic [7:0] c);
			casez (c)
				8'b0???????: return 1;
				8'b110?????: return 2;
				8'b1110????: return 3;
				8'b11110???: return 4;
				default: return 0;
			endcase
		endfunction

		// complete sequence at win[p]: continuations, shortest form, range, surrogates
		function bit well_formed(int p, int len);
			int unsigned cp;
			int          k;
			if (len == 1)
				return 1'b1;
			case (len)
				2: cp = win[p][4:0];
				3: cp = win[p][3:0];
				default: cp = win[p][2:0];
			endcase
			for (k = 1; k < len; k++) begin
				if (win[p + k][7:6] != 2'b10)
					return 1'b0;
				cp = (cp << 6) | win[p + k][5:0];
			end
			if (len == 2 && cp < 'h80)
				return 1'b0;
			if (len == 3 && cp < 'h800)
				return 1'b0;
			if (len == 4 && cp < 'h10000)
				return 1'b0;
			if (cp > 'h10FFFF)
				return 1'b0;
			if (cp >= 'hD800 && cp <= 'hDFFF)
				return 1'b0;
			return 1'b1;
		endfunction

		function void absorb_beat(in_beat_t b);
			out_beat_t run[$];
			out_beat_t o;
			int        n;
			int        pos;
			int        len;
			int        k;
			n = 0;
			pos = 0;
			for (k = 0; k < held_n; k++) begin
				win[n] = held[k];
				n++;
			end
			if (b.byte_present) begin
				win[n] = b.in_byte;
				n++;
			end
			while (pos < n) begin
				len = lead_len(win[pos]);
				// incomplete sequence waits unless the string ends here
				if (len != 0 && n - pos < len && !b.string_end)
					break;
				if (len != 0 && n - pos >= len && well_formed(pos, len)) begin
					for (k = 0; k < len; k++) begin
						o = '0;
						o.out_byte = win[pos + k];
						run = {run, o};
					end
					pos += len;
				end else begin
					// reject: EF BF BD, drop one byte, rescan the rest
					o = '0;
					o.is_replacement = 1'b1;
					o.out_byte = REPL_B0;
					run = {run, o};
					o.out_byte = REPL_B1;
					run = {run, o};
					o.out_byte = REPL_B2;
					run = {run, o};
					pos++;
				end
			end
			held_n = n - pos;
			for (k = 0; k < held_n; k++)
				held[k] = win[pos + k];
			if (run.size() > 0) begin
				o = run[run.size() - 1];
				o.run_last = 1'b1;
				o.string_last = b.string_end;
				run[run.size() - 1] = o;
			end
			repaired_q = {repaired_q, run};
		endfunction

		function void compare_beat(out_beat_t r);
			out_beat_t e;
			if (repaired_q.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected beat byte=%h repl=%b run_last=%b string_last=%b",
					$time, r.out_byte, r.is_replacement, r.run_last, r.string_last);
				return;
			end
			e = repaired_q.pop_front();
			if (r.out_byte !== e.out_byte || r.is_replacement !== e.is_replacement ||
					r.run_last !== e.run_last || r.string_last !== e.string_last) begin
				mismatches++;
				$display("%0t: mismatch expected byte=%h repl=%b run_last=%b string_last=%b",
					$time, e.out_byte, e.is_replacement, e.run_last, e.string_last);
				$display("%0t:          actual   byte=%h repl=%b run_last=%b string_last=%b",
					$time, r.out_byte, r.is_replacement, r.run_last, r.string_last);
			end
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      push;
	logic      full;
	in_beat_t  item;
	logic      empty;
	logic      pop;
	out_beat_t result;

	repair_board board = new();

	// idle percentages for the current phase, read by both drivers
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	// beats that carry a byte or an end mark (idle beats are not counted)
	int beats_sent = 0;

	utf8_sanitizer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("status: fail");
		$finish;
	end

	// Receiver: pop is chosen at each falling edge; a result beat is taken
	// at the rising edge where pop is high and empty is low.
	initial begin
		pop = 1'b0;
		forever begin
			@(negedge clk);
			pop = ($urandom_range(99) >= recv_stall_pct);
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && pop && !empty)
				board.compare_beat(result);
		end
	end

	// Sends one beat; called at a falling edge, returns at a falling edge.
	// push stays high between back-to-back beats and drops only for a gap.
	task automatic send_beat(input in_beat_t b);
		while ($urandom_range(99) < send_idle_pct) begin
			push = 1'b0;
			@(negedge clk);
		end
		push = 1'b1;
		item = b;
		@(posedge clk);
		while (full)
			@(posedge clk);
		board.absorb_beat(b);
		if (b.byte_present || b.string_end)
			beats_sent++;
		@(negedge clk);
	endtask

	task automatic send_byte(input logic [7:0] c, input logic last);
		send_beat(in_beat_t'{c, 1'b1, last});
	endtask

	// stop sending until every predicted beat has come out
	task automatic drain();
		push = 1'b0;
		while (board.repaired_q.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// One string of random units: mostly well-formed sequences, the rest
	// overlong, surrogate, out-of-range, truncated, broken or stray bytes.
	task automatic send_string();
		logic [7:0]  str_q[$];
		logic [7:0]  u[4];
		logic [20:0] cp;
		int          len;
		int          keep;
		int          roll;
		int          nseq;
		int          i;
		int          k;
		int          p;
		nseq = $urandom_range(1, 6);
		for (i = 0; i < nseq; i++) begin
			roll = $urandom_range(99);
			len = $urandom_range(1, 4);
			keep = len;
			if (roll < 55 || (roll >= 72 && roll < 90)) begin
				if (roll >= 72)
					len = $urandom_range(2, 4);
				keep = len;
				case (len)
					1: cp = 21'($urandom_range('h7F, 0));
					2: cp = 21'($urandom_range('h7FF, 'h80));
					3: begin
						cp = 21'($urandom_range('hFFFF, 'h800));
						if (cp >= 'hD800 && cp <= 'hDFFF)
							cp = cp ^ 21'h1000;
					end
					default: cp = 21'($urandom_range('h10FFFF, 'h10000));
				endcase
			end else if (roll < 62) begin
				// overlong form
				len = $urandom_range(2, 4);
				keep = len;
				case (len)
					2: cp = 21'($urandom_range('h7F, 0));
					3: cp = 21'($urandom_range('h7FF, 0));
					default: cp = 21'($urandom_range('hFFFF, 0));
				endcase
			end else if (roll < 67) begin
				len = 3;
				keep = 3;
				cp = 21'($urandom_range('hDFFF, 'hD800));
			end else if (roll < 72) begin
				len = 4;
				keep = 4;
				cp = 21'($urandom_range('h1FFFFF, 'h110000));
			end else begin
				len = 0;
				keep = 1;
				cp = '0;
			end
			case (len)
				1: u[0] = {1'b0, cp[6:0]};
				2: begin
					u[0] = {3'b110, cp[10:6]};
					u[1] = {2'b10, cp[5:0]};
				end
				3: begin
					u[0] = {4'b1110, cp[15:12]};
					u[1] = {2'b10, cp[11:6]};
					u[2] = {2'b10, cp[5:0]};
				end
				4: begin
					u[0] = {5'b11110, cp[20:18]};
					u[1] = {2'b10, cp[17:12]};
					u[2] = {2'b10, cp[11:6]};
					u[3] = {2'b10, cp[5:0]};
				end
				default: u[0] = 8'($urandom_range(255));
			endcase
			if (roll >= 72 && roll < 80) begin
				// truncated sequence
				keep = $urandom_range(1, len - 1);
			end else if (roll >= 80 && roll < 90) begin
				// one continuation byte broken
				p = $urandom_range(1, len - 1);
				u[p] = 8'($urandom_range(255));
				if (u[p][7:6] == 2'b10)
					u[p][6] = 1'b1;
			end
			for (k = 0; k < keep; k++)
				str_q = {str_q, u[k]};
		end
		// end mark on the last byte, as a separate beat, or not at all
		roll = $urandom_range(99);
		foreach (str_q[k]) begin
			if ($urandom_range(99) < 8)
				send_beat(in_beat_t'{8'($urandom_range(255)), 1'b0, 1'b0});
			send_byte(str_q[k], (k == str_q.size() - 1) && roll < 55);
		end
		if (roll >= 55 && roll < 85)
			send_beat(in_beat_t'{8'($urandom_range(255)), 1'b0, 1'b1});
	endtask

	task automatic random_phase(input int send_pct, input int recv_pct);
		int start;
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		start = beats_sent;
		while (beats_sent - start < BEATS_PER_PHASE)
			send_string();
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		item = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed beats, no idling
		send_beat(in_beat_t'{8'hFF, 1'b0, 1'b1}); // end mark on an empty string: no output
		send_beat(in_beat_t'{8'h00, 1'b0, 1'b0}); // idle beat: nothing happens
		send_byte(8'h00, 1'b1);
		send_byte(8'h7F, 1'b0);
		send_byte(8'h80, 1'b0);                   // stray continuation
		send_byte(8'hFF, 1'b1);                   // byte that never leads
		send_byte(8'hC2, 1'b0);                   // smallest two-byte code point
		send_byte(8'h80, 1'b0);
		send_byte(8'hC1, 1'b0);                   // overlong two-byte form
		send_byte(8'hBF, 1'b1);
		send_byte(8'hED, 1'b0);                   // surrogate
		send_byte(8'hA0, 1'b0);
		send_byte(8'h80, 1'b1);
		send_byte(8'hF4, 1'b0);                   // above U+10FFFF
		send_byte(8'h90, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h80, 1'b1);
		send_byte(8'hF4, 1'b0);                   // U+10FFFF itself
		send_byte(8'h8F, 1'b0);
		send_byte(8'hBF, 1'b0);
		send_byte(8'hBF, 1'b0);
		send_byte(8'hE1, 1'b0);                   // bad continuation before the end
		send_byte(8'h41, 1'b1);
		send_byte(8'hF0, 1'b0);                   // left incomplete, then flushed
		send_beat(in_beat_t'{8'h00, 1'b0, 1'b1});
		// hold off the sender until the output has fully caught up
		drain();

		random_phase(0, 0);
		random_phase(54, 0);
		random_phase(0, 54);
		random_phase(6, 6);

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (board.repaired_q.size() != 0) begin
			$display("%0t: %0d expected beats never arrived, next byte=%h",
				$time, board.repaired_q.size(), board.repaired_q[0].out_byte);
			board.mismatches++;
		end
		if (board.mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
